[src/utfdec_pkg.sv]
// ----------------------------------------------------------------------------
// utfdec_pkg
// Shared types and constants of the UTF-8 to UCS-2 stream decoder.
// ----------------------------------------------------------------------------
package utfdec_pkg;

    localparam int unsigned MaxRes = 3;

    localparam logic [15:0] REPL_UNIT = 16'h003F;

    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] MASK_LEAD5 = 8'hFC;
    localparam logic [7:0] MASK_LEAD6 = 8'hFE;
    localparam logic [7:0] CODE_LEAD2 = 8'hC0;
    localparam logic [7:0] CODE_LEAD3 = 8'hE0;
    localparam logic [7:0] CODE_LEAD4 = 8'hF0;
    localparam logic [7:0] CODE_LEAD5 = 8'hF8;
    localparam logic [7:0] CODE_LEAD6 = 8'hFC;

    localparam logic [2:0] DROP_LEAD4 = 3'd3;
    localparam logic [2:0] DROP_LEAD5 = 3'd4;
    localparam logic [2:0] DROP_LEAD6 = 3'd5;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_replacement;
        logic        last_of_run;
    } t_out;

    typedef struct packed {
        logic [1:0]       count;
        t_out [MaxRes-1:0] item;
    } t_res_set;

endpackage

[src/utfdec_core.sv]
// ----------------------------------------------------------------------------
// utfdec_core
// Decode state and per-byte result list: one byte in, up to three words out.
// ----------------------------------------------------------------------------
module utfdec_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  utfdec_pkg::t_in      i_data,
    output utfdec_pkg::t_res_set o_res
);
    import utfdec_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_TWO   = 2'd1,
        MODE_THREE = 2'd2,
        MODE_DROP  = 2'd3
    } t_mode;

    t_mode       r_mode,    n_mode;
    logic [2:0]  r_remain,  n_remain;
    logic        r_held,    n_held;
    logic [15:0] r_partial, n_partial;

    t_mode       lead_mode;
    logic [2:0]  lead_remain;
    logic [15:0] lead_partial;
    logic        lead_put;
    logic        lead_repl;

    logic [7:0]  b;
    logic        cont;

    assign b    = i_data.in_byte;
    assign cont = (b[7:6] == 2'b10);

    always_comb begin
        lead_mode    = MODE_IDLE;
        lead_remain  = 3'd0;
        lead_partial = 16'd0;
        lead_put     = 1'b0;
        lead_repl    = 1'b0;
        priority if (!b[7]) begin
            lead_put = (b != 8'd0);
        end else if ((b & MASK_LEAD2) == CODE_LEAD2) begin
            lead_mode    = MODE_TWO;
            lead_remain  = 3'd1;
            lead_partial = {5'd0, b[4:0], 6'd0};
        end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
            lead_mode    = MODE_THREE;
            lead_remain  = 3'd2;
            lead_partial = {b[3:0], 12'd0};
        end else if ((b & MASK_LEAD4) == CODE_LEAD4) begin
            lead_mode   = MODE_DROP;
            lead_remain = DROP_LEAD4;
            lead_put    = 1'b1;
            lead_repl   = 1'b1;
        end else if ((b & MASK_LEAD5) == CODE_LEAD5) begin
            lead_mode   = MODE_DROP;
            lead_remain = DROP_LEAD5;
            lead_put    = 1'b1;
            lead_repl   = 1'b1;
        end else if ((b & MASK_LEAD6) == CODE_LEAD6) begin
            lead_mode   = MODE_DROP;
            lead_remain = DROP_LEAD6;
            lead_put    = 1'b1;
            lead_repl   = 1'b1;
        end else begin
            lead_put  = 1'b1;
            lead_repl = 1'b1;
        end
    end

    always_comb begin
        logic [1:0]  cnt;
        logic [15:0] v;
        logic        do_lead;

        n_mode    = r_mode;
        n_remain  = r_remain;
        n_held    = r_held;
        n_partial = r_partial;
        cnt       = 2'd0;
        do_lead   = 1'b0;
        v         = r_partial | {10'd0, b[5:0]};
        o_res     = '0;

        unique case (r_mode)
            MODE_TWO: begin
                if (cont) begin
                    n_mode    = MODE_IDLE;
                    n_remain  = 3'd0;
                    n_held    = 1'b0;
                    n_partial = 16'd0;
                    if (v != 16'd0) begin
                        o_res.item[cnt] = '{code_unit: v, is_replacement: 1'b0,
                                            last_of_run: 1'b0};
                        cnt = cnt + 2'd1;
                    end
                end else begin
                    o_res.item[cnt] = '{code_unit: REPL_UNIT, is_replacement: 1'b1,
                                        last_of_run: 1'b0};
                    cnt = cnt + 2'd1;
                    do_lead = 1'b1;
                end
            end
            MODE_THREE: begin
                if (cont) begin
                    if (!r_held) begin
                        n_partial = r_partial | {4'd0, b[5:0], 6'd0};
                        n_held    = 1'b1;
                        n_remain  = 3'd1;
                    end else begin
                        n_mode    = MODE_IDLE;
                        n_remain  = 3'd0;
                        n_held    = 1'b0;
                        n_partial = 16'd0;
                        if (v != 16'd0) begin
                            o_res.item[cnt] = '{code_unit: v, is_replacement: 1'b0,
                                                last_of_run: 1'b0};
                            cnt = cnt + 2'd1;
                        end
                    end
                end else begin
                    o_res.item[cnt] = '{code_unit: REPL_UNIT, is_replacement: 1'b1,
                                        last_of_run: 1'b0};
                    cnt = cnt + 2'd1;
                    if (r_held) begin
                        o_res.item[cnt] = '{code_unit: REPL_UNIT, is_replacement: 1'b1,
                                            last_of_run: 1'b0};
                        cnt = cnt + 2'd1;
                    end
                    do_lead = 1'b1;
                end
            end
            MODE_DROP: begin
                if (r_remain <= 3'd1) begin
                    n_mode    = MODE_IDLE;
                    n_remain  = 3'd0;
                    n_held    = 1'b0;
                    n_partial = 16'd0;
                end else begin
                    n_remain = r_remain - 3'd1;
                end
            end
            default: begin
                do_lead = 1'b1;
            end
        endcase

        if (do_lead) begin
            n_mode    = lead_mode;
            n_remain  = lead_remain;
            n_held    = 1'b0;
            n_partial = lead_partial;
            if (lead_put && cnt != 2'd3) begin
                o_res.item[cnt] = '{code_unit: lead_repl ? REPL_UNIT : {8'd0, b},
                                    is_replacement: lead_repl, last_of_run: 1'b0};
                cnt = cnt + 2'd1;
            end
        end

        if (i_data.end_of_string) begin
            if (n_mode == MODE_TWO || n_mode == MODE_THREE) begin
                if (cnt != 2'd3) begin
                    o_res.item[cnt] = '{code_unit: REPL_UNIT, is_replacement: 1'b1,
                                        last_of_run: 1'b0};
                    cnt = cnt + 2'd1;
                end
                if (n_mode == MODE_THREE && n_held && cnt != 2'd3) begin
                    o_res.item[cnt] = '{code_unit: REPL_UNIT, is_replacement: 1'b1,
                                        last_of_run: 1'b0};
                    cnt = cnt + 2'd1;
                end
            end
            n_mode    = MODE_IDLE;
            n_remain  = 3'd0;
            n_held    = 1'b0;
            n_partial = 16'd0;
        end

        if (cnt != 2'd0) begin
            o_res.item[cnt - 2'd1].last_of_run = 1'b1;
        end
        o_res.count = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_remain  <= 3'd0;
            r_held    <= 1'b0;
            r_partial <= 16'd0;
        end else if (i_accept) begin
            r_mode    <= n_mode;
            r_remain  <= n_remain;
            r_held    <= n_held;
            r_partial <= n_partial;
        end
    end

endmodule

[src/utfdec_obuf.sv]
// ----------------------------------------------------------------------------
// utfdec_obuf
// Result register: holds the words of one byte and hands them out in order.
// ----------------------------------------------------------------------------
module utfdec_obuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  utfdec_pkg::t_res_set i_res,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output utfdec_pkg::t_out     o_out_data
);
    import utfdec_pkg::*;

    t_out [MaxRes-1:0] r_item;
    logic [1:0]        r_left;
    logic              pop;
    logic              load;

    assign o_out_valid = (r_left != 2'd0);
    assign o_out_data  = r_item[0];
    assign pop         = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_left == 2'd0) || (r_left == 2'd1 && i_out_ready);
    assign load        = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
        end else if (load) begin
            r_left <= i_res.count;
        end else if (pop) begin
            r_left <= r_left - 2'd1;
        end
    end

    // advance the word list one place per taken word
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_res.item;
        end else if (pop) begin
            r_item <= {r_item[MaxRes-1], r_item[MaxRes-1:1]};
        end
    end

endmodule

[src/utf8_to_ucs2_stream_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_ucs2_stream_decoder
// UTF-8 byte stream in, UCS-2 code units out, with '?' for bad sequences.
// ----------------------------------------------------------------------------
// Input channel: one UTF-8 byte per word plus an end-of-string flag, taken
// on i_in_valid and o_in_ready. Output channel: one code unit per word with
// replacement and last-of-run flags, given on o_out_valid and i_out_ready.
// A byte makes zero to three output words; the flag last_of_run marks the
// final word of each byte.
// The first word of a byte shows in the cycle after the byte is taken.
// One byte per cycle while each byte makes at most one word and the receiver
// is ready; a byte that makes more words holds the input until its last word
// can leave the single result register, draining one word per ready cycle.
// Reset (synchronous, active low) returns the decoder to idle and empties
// the result register. When the receiver stalls, the pending words hold and
// o_in_ready drops once the last of them cannot leave in this cycle.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_stream_decoder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  utfdec_pkg::t_in  i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output utfdec_pkg::t_out o_out_data
);
    import utfdec_pkg::*;

    t_res_set res;
    logic     accept;

    assign accept = i_in_valid && o_in_ready;

    utfdec_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_in_data),
        .o_res    (res)
    );

    utfdec_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_res       (res),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[src/utfdec_checker.sv]
// ----------------------------------------------------------------------------
// utfdec_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utfdec_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input utfdec_pkg::t_in  i_in_data,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input utfdec_pkg::t_out o_out_data
);
    import utfdec_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed under stall");

    a_repl_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_replacement |-> o_out_data.code_unit == REPL_UNIT)
        else $error("replacement word is not '?'");

    a_no_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.code_unit != 16'd0)
        else $error("zero code unit given");

    a_run_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last_of_run |-> !o_in_ready)
        else $error("input taken with a run still pending");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind utf8_to_ucs2_stream_decoder utfdec_checker u_chk (.*);

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 to UCS-2 stream decoder.
// ----------------------------------------------------------------------------
// Bytes go in from a queue through a bursty valid/ready driver. Each accepted
// byte runs through a local decoder model, which queues the code units it
// should produce. The output monitor stalls on its own pattern and checks
// every word it takes against the oldest queued unit, field by field. The
// stimulus is a directed set of edge sequences followed by random strings:
// mostly well-formed sequences, with broken, cut-off and stray bytes mixed in.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utfdec_pkg::*;

    localparam logic [1:0] CONT_TAG = 2'b10;
    localparam int         N_BYTES = 160;

    typedef enum logic [1:0] {
        DEC_IDLE  = 2'd0,
        DEC_TWO   = 2'd1,
        DEC_THREE = 2'd2,
        DEC_DROP  = 2'd3
    } t_dec_mode;

    typedef struct {
        t_in word;
        bit  hold;
    } t_pending;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    t_pending byte_q[$];
    t_out     due_units[$];
    logic     in_taken = 1'b0;

    t_dec_mode   dec_mode = DEC_IDLE;
    logic [2:0]  need = '0;
    logic        held = 1'b0;
    logic [15:0] acc = '0;
    t_out        run_buf[MaxRes];
    int          run_len;

    int err_cnt = 0;
    int n_bytes = 0;
    int n_words = 0;
    int n_repl = 0;
    int n_eos = 0;
    int total = 0;
    int gap_left = 0;
    int burst_left = 0;
    int unsigned cyc = 0;

    utf8_to_ucs2_stream_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $realtime, what);
        err_cnt++;
    endtask

    task automatic push_unit(input logic [15:0] unit, input logic repl);
        if (run_len < MaxRes) begin
            run_buf[run_len].code_unit = unit;
            run_buf[run_len].is_replacement = repl;
            run_buf[run_len].last_of_run = 1'b0;
            run_len++;
        end
    endtask

    task automatic clear_decoder();
        dec_mode = DEC_IDLE;
        need = '0;
        held = 1'b0;
        acc = '0;
    endtask

    task automatic open_lead(input logic [7:0] b);
        clear_decoder();
        if (b[7] == 1'b0) begin
            if (b != 8'h00) push_unit({8'h00, b}, 1'b0);
        end else if ((b & MASK_LEAD2) == CODE_LEAD2) begin
            dec_mode = DEC_TWO;
            need = 3'd1;
            acc = {5'b0, b[4:0], 6'b0};
        end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
            dec_mode = DEC_THREE;
            need = 3'd2;
            acc = {b[3:0], 12'b0};
        end else if ((b & MASK_LEAD4) == CODE_LEAD4) begin
            push_unit(REPL_UNIT, 1'b1);
            dec_mode = DEC_DROP;
            need = DROP_LEAD4;
        end else if ((b & MASK_LEAD5) == CODE_LEAD5) begin
            push_unit(REPL_UNIT, 1'b1);
            dec_mode = DEC_DROP;
            need = DROP_LEAD5;
        end else if ((b & MASK_LEAD6) == CODE_LEAD6) begin
            push_unit(REPL_UNIT, 1'b1);
            dec_mode = DEC_DROP;
            need = DROP_LEAD6;
        end else begin
            push_unit(REPL_UNIT, 1'b1);
        end
    endtask

    task automatic decode_byte(input t_in w);
        logic [7:0]  b;
        logic        is_cont;
        logic [15:0] v;
        b = w.in_byte;
        is_cont = (b[7:6] == CONT_TAG);
        run_len = 0;
        case (dec_mode)
            DEC_TWO: begin
                if (is_cont) begin
                    v = acc | {10'b0, b[5:0]};
                    clear_decoder();
                    if (v != 16'h0000) push_unit(v, 1'b0);
                end else begin
                    push_unit(REPL_UNIT, 1'b1);
                    open_lead(b);
                end
            end
            DEC_THREE: begin
                if (is_cont && !held) begin
                    acc = acc | {4'b0, b[5:0], 6'b0};
                    held = 1'b1;
                    need = 3'd1;
                end else if (is_cont) begin
                    v = acc | {10'b0, b[5:0]};
                    clear_decoder();
                    if (v != 16'h0000) push_unit(v, 1'b0);
                end else begin
                    push_unit(REPL_UNIT, 1'b1);
                    if (held) push_unit(REPL_UNIT, 1'b1);
                    open_lead(b);
                end
            end
            DEC_DROP: begin
                if (need <= 3'd1) clear_decoder();
                else need = need - 3'd1;
            end
            default: open_lead(b);
        endcase
        if (w.end_of_string) begin
            if (dec_mode == DEC_TWO) begin
                push_unit(REPL_UNIT, 1'b1);
            end else if (dec_mode == DEC_THREE) begin
                push_unit(REPL_UNIT, 1'b1);
                if (held) push_unit(REPL_UNIT, 1'b1);
            end
            clear_decoder();
        end
        if (run_len > 0) run_buf[run_len-1].last_of_run = 1'b1;
        for (int k = 0; k < run_len; k++) due_units.push_back(run_buf[k]);
    endtask

    task automatic add_byte(input logic [7:0] b, input logic eos, input bit hold);
        t_pending p;
        p.word.in_byte = b;
        p.word.end_of_string = eos;
        p.hold = hold;
        byte_q.push_back(p);
    endtask

    function automatic logic [7:0] rand_cont();
        return {CONT_TAG, 6'($urandom_range(0, 63))};
    endfunction

    task automatic add_random_string();
        int   kind;
        int   cnt;
        logic eos;
        bit   hold;
        kind = $urandom_range(0, 15);
        eos = ($urandom_range(0, 7) == 0);
        hold = (byte_q.size() % 50 == 0);
        case (kind)
            0, 1, 2, 3: begin
                add_byte(8'($urandom_range(0, 127)), eos, hold);
            end
            4, 5, 6: begin
                add_byte(8'($urandom_range(8'hC0, 8'hDF)), 1'b0, hold);
                add_byte(rand_cont(), eos, 1'b0);
            end
            7, 8, 9: begin
                add_byte(8'($urandom_range(8'hE0, 8'hEF)), 1'b0, hold);
                add_byte(rand_cont(), $urandom_range(0, 19) == 0, 1'b0);
                add_byte(rand_cont(), eos, 1'b0);
            end
            10: begin
                cnt = $urandom_range(3, 5);
                case (cnt)
                    3: add_byte(8'($urandom_range(8'hF0, 8'hF7)), 1'b0, hold);
                    4: add_byte(8'($urandom_range(8'hF8, 8'hFB)), 1'b0, hold);
                    default: add_byte(8'($urandom_range(8'hFC, 8'hFD)), 1'b0, hold);
                endcase
                for (int k = 0; k < cnt; k++) begin
                    add_byte(8'($urandom_range(0, 255)), k == cnt - 1 && eos, 1'b0);
                end
            end
            11, 12: begin
                add_byte(8'($urandom_range(8'hC0, 8'hEF)), 1'b0, hold);
                if ($urandom_range(0, 1) == 1) add_byte(rand_cont(), 1'b0, 1'b0);
                add_byte(8'($urandom_range(0, 255)), eos, 1'b0);
            end
            default: begin
                add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, hold);
            end
        endcase
    endtask

    // input driver: bursts with random gaps
    always @(negedge i_clk) begin : drive_in
        t_pending nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && !in_taken)) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (byte_q.size() == 0 || (byte_q[0].hold && due_units.size() != 0)) begin
                i_in_valid <= 1'b0;
            end else begin
                nxt = byte_q.pop_front();
                i_in_valid <= 1'b1;
                i_in_data <= nxt.word;
                if (burst_left > 0) begin
                    burst_left = burst_left - 1;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end
            end
        end
    end

    // output stall pattern, with a style chosen by bits 7:6 of the cycle counter
    always @(negedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            case (cyc[7:6])
                2'd0: i_out_ready <= 1'b1;
                2'd1: i_out_ready <= 1'($urandom_range(0, 1));
                2'd2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= (cyc[2:0] != 3'd0);
            endcase
        end
    end

    always @(posedge i_clk) begin : watch_out
        t_out want;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                n_words++;
                if (o_out_data.is_replacement) n_repl++;
                if (due_units.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h", o_out_data.code_unit));
                end else begin
                    want = due_units.pop_front();
                    if (o_out_data.code_unit !== want.code_unit)
                        report_mismatch($sformatf("code_unit %h, want %h",
                                                  o_out_data.code_unit, want.code_unit));
                    if (o_out_data.is_replacement !== want.is_replacement)
                        report_mismatch($sformatf("is_replacement %b, want %b",
                                                  o_out_data.is_replacement,
                                                  want.is_replacement));
                    if (o_out_data.last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("last_of_run %b, want %b",
                                                  o_out_data.last_of_run, want.last_of_run));
                end
            end
            if (i_in_valid && o_in_ready) begin
                n_bytes++;
                if (i_in_data.end_of_string) n_eos++;
                decode_byte(i_in_data);
            end
        end
    end

    initial begin
        // plain, zero and overlong zero
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h7F, 1'b0, 1'b0);
        add_byte(8'hC0, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0);
        // largest two- and three-byte values
        add_byte(8'hDF, 1'b0, 1'b0);
        add_byte(8'hBF, 1'b0, 1'b0);
        add_byte(8'hEF, 1'b0, 1'b0);
        add_byte(8'hBF, 1'b0, 1'b0);
        add_byte(8'hBF, 1'b0, 1'b0);
        // broken two-byte, broken three-byte with held continuation
        add_byte(8'hC3, 1'b0, 1'b0);
        add_byte(8'h41, 1'b0, 1'b0);
        add_byte(8'hE2, 1'b0, 1'b0);
        add_byte(8'h82, 1'b0, 1'b0);
        add_byte(8'hC3, 1'b0, 1'b0);
        add_byte(8'hA9, 1'b0, 1'b0);
        // stray bytes, after draining every pending word
        add_byte(8'h80, 1'b0, 1'b1);
        add_byte(8'hFE, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        // four-byte lead, three dropped
        add_byte(8'hF0, 1'b0, 1'b0);
        add_byte(8'h41, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        // five- and six-byte leads cut off by end of string
        add_byte(8'hFB, 1'b0, 1'b0);
        add_byte(8'h41, 1'b1, 1'b0);
        add_byte(8'hFD, 1'b1, 1'b0);
        // three-byte cut off with held continuation
        add_byte(8'hE2, 1'b0, 1'b0);
        add_byte(8'h82, 1'b1, 1'b0);
        while (byte_q.size() < N_BYTES) add_random_string();
        total = byte_q.size();

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_bytes == total);
        wait (due_units.size() == 0);
        repeat (20) @(posedge i_clk);
        $display("Decoded %0d bytes (%0d end-of-string marks) into %0d words, %0d replacements.",
                 n_bytes, n_eos, n_words, n_repl);
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("timeout");
        $display("simulation failed");
        $finish;
    end

endmodule
